@@ hw/rtl/tcba_pkg.sv @@
// ----------------------------------------------------------------------------
// tcba_pkg
// Shared types and constants for the three-channel block averager.
// ----------------------------------------------------------------------------
package tcba_pkg;

  localparam int DEFAULT_MAX_WINDOW = 4096;

  localparam int UV_W       = 16;
  localparam int WIDE_W     = 20;
  localparam int UV_SUM_W   = 28;
  localparam int WIDE_SUM_W = 32;
  localparam int DIV_W      = 32;
  localparam int DATA_W     = 56;
  localparam int WLEN_W     = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH   = 2'd0,
    CFG_CHANNEL_SELECT  = 2'd1,
    CFG_CONTINUOUS_MODE = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    SEL_ALL = 2'd0,
    SEL_UV  = 2'd1,
    SEL_VIS = 2'd2,
    SEL_IR  = 2'd3
  } chan_sel_t;

  typedef struct packed {
    logic [WIDE_SUM_W-1:0] infrared_sum;
    logic [WIDE_SUM_W-1:0] visible_sum;
    logic [UV_SUM_W-1:0]   uv_sum;
  } sums_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

endpackage

@@ hw/rtl/three_channel_block_averager_top.sv @@
// ----------------------------------------------------------------------------
// three_channel_block_averager_top
// Accumulate-and-dump averager over UV, visible and infrared samples.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream (s_*) takes one sample set per word. Selected channels
//   are summed over a window of window_length+1 samples (capped at
//   MAX_WINDOW); the word that closes the window produces one result word
//   on the master stream (m_*) holding each sum divided by the window size,
//   truncated. Unselected channels read as zero.
//   The cfg_* channel writes a register by index: 0 window length,
//   1 channel select, 2 continuous mode; other indexes are dropped. Write
//   only while the block is idle. cfg_ready is always high.
//   With the back end idle, the closing window's sums pass through the
//   queue, the three dividers and the output register before m_tvalid
//   rises. Three restoring dividers run side by side, one quotient bit per
//   cycle; a two-entry queue of window sums lets samples keep flowing
//   meanwhile, one per cycle while the queue has room. s_tready falls only
//   when that queue is full.
//   When m_tready is low the result word is held; the back end may finish
//   the next division and then waits on the output register.
//   Reset clears all sums, the sample count and the one-shot stop flag, and
//   sets the registers to window length 0, all channels, one-shot mode.
//   After its one result in one-shot mode the block accepts and drops
//   every further sample until reset.
// ----------------------------------------------------------------------------
module three_channel_block_averager_top import tcba_pkg::*; #(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst,
  // Sample stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_W-1:0]     s_tdata,   // uv_sample, visible_sample, infrared_sample
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_W-1:0]     m_tdata,   // uv_average, visible_average, infrared_average
  // Register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NW = $clog2(MAX_WINDOW + 1);

  logic [WLEN_W-1:0] window_length;
  chan_sel_t         channel_select;
  logic              continuous_mode;

  logic              push;
  sums_t             push_sums;
  logic [NW-1:0]     push_size;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [$bits(sums_t)+NW-1:0] q_head;

  logic [UV_W-1:0]   uv_average;
  logic [WIDE_W-1:0] visible_average;
  logic [WIDE_W-1:0] infrared_average;

  // Register file: always ready, unknown indexes drop the word
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= '0;
      channel_select  <= SEL_ALL;
      continuous_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH:   window_length   <= cfg_data[WLEN_W-1:0];
        CFG_CHANNEL_SELECT:  channel_select  <= chan_sel_t'(cfg_data[1:0]);
        CFG_CONTINUOUS_MODE: continuous_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: gate and accumulate samples, push sums at window end
  tcba_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .uv_sample       (s_tdata[15:0]),
    .visible_sample  (s_tdata[35:16]),
    .infrared_sample (s_tdata[55:36]),
    .window_length   (window_length),
    .channel_select  (channel_select),
    .continuous_mode (continuous_mode),
    .q_full          (q_full),
    .push            (push),
    .push_sums       (push_sums),
    .push_size       (push_size)
  );

  // Queue of finished windows: sums with their divisor
  tcba_queue #(.WIDTH($bits(sums_t) + NW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_size, push_sums}),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: divide and hold the result word
  tcba_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_sums           (sums_t'(q_head[$bits(sums_t)-1:0])),
    .q_size           (q_head[$bits(sums_t)+NW-1:$bits(sums_t)]),
    .q_pop            (q_pop),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .uv_average       (uv_average),
    .visible_average  (visible_average),
    .infrared_average (infrared_average)
  );

  assign m_tdata = {infrared_average, visible_average, uv_average};

endmodule

@@ hw/rtl/tcba_queue.sv @@
// ----------------------------------------------------------------------------
// tcba_queue
// Small FIFO of finished window sums between front and back.
// ----------------------------------------------------------------------------
module tcba_queue import tcba_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/tcba_front.sv @@
// ----------------------------------------------------------------------------
// tcba_front
// Sample intake: gate by channel select, accumulate, detect window end.
// ----------------------------------------------------------------------------
module tcba_front import tcba_pkg::*; #(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
  localparam int NW = $clog2(MAX_WINDOW + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [UV_W-1:0]   uv_sample,
  input  logic [WIDE_W-1:0] visible_sample,
  input  logic [WIDE_W-1:0] infrared_sample,
  input  logic [WLEN_W-1:0] window_length,
  input  chan_sel_t         channel_select,
  input  logic              continuous_mode,
  input  logic              q_full,
  output logic              push,
  output sums_t             push_sums,
  output logic [NW-1:0]     push_size
);

  sums_t         sums;
  sums_t         sums_next;
  logic [NW-1:0] samples_taken;
  logic [NW-1:0] taken_next;
  logic [NW-1:0] win_size;
  logic [31:0]   len_ext;
  logic          finished;
  logic          accept;
  logic          window_end;

  assign s_tready = finished || !q_full;
  assign accept   = s_tvalid && s_tready && !finished;

  // Window size saturates at MAX_WINDOW
  always_comb begin
    len_ext = 32'(window_length) + 32'd1;
    if (len_ext > 32'(MAX_WINDOW)) begin
      win_size = NW'(MAX_WINDOW);
    end else begin
      win_size = NW'(len_ext);
    end
  end

  always_comb begin
    sums_next = sums;
    if (channel_select == SEL_ALL || channel_select == SEL_UV) begin
      sums_next.uv_sum = sums.uv_sum + UV_SUM_W'(uv_sample);
    end
    if (channel_select == SEL_ALL || channel_select == SEL_VIS) begin
      sums_next.visible_sum = sums.visible_sum + WIDE_SUM_W'(visible_sample);
    end
    if (channel_select == SEL_ALL || channel_select == SEL_IR) begin
      sums_next.infrared_sum = sums.infrared_sum + WIDE_SUM_W'(infrared_sample);
    end
    taken_next = samples_taken + 1'b1;
    window_end = (taken_next >= win_size);
  end

  assign push      = accept && window_end;
  assign push_sums = sums_next;
  assign push_size = win_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums          <= '0;
      samples_taken <= '0;
      finished      <= 1'b0;
    end else if (accept) begin
      if (window_end) begin
        sums          <= '0;
        samples_taken <= '0;
        finished      <= !continuous_mode;
      end else begin
        sums          <= sums_next;
        samples_taken <= taken_next;
      end
    end
  end

endmodule

@@ hw/rtl/tcba_div.sv @@
// ----------------------------------------------------------------------------
// tcba_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcba_div import tcba_pkg::*; #(
  parameter int DIVISOR_W = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_W-1:0]     quotient
);

  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [STEP_W-1:0]    step;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 take;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dsr};
    take  = (trial >= {1'b0, dsr});
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dsr  <= divisor;
      step <= '0;
    end else if (busy) begin
      quo  <= {quo[DIV_W-2:0], take};
      rem  <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == STEP_W'(DIV_W - 1)) begin
      busy <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/tcba_back.sv @@
// ----------------------------------------------------------------------------
// tcba_back
// Divide queued window sums by the window size and hold the result word.
// ----------------------------------------------------------------------------
module tcba_back import tcba_pkg::*; #(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
  localparam int NW = $clog2(MAX_WINDOW + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  sums_t             q_sums,
  input  logic [NW-1:0]     q_size,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [UV_W-1:0]   uv_average,
  output logic [WIDE_W-1:0] visible_average,
  output logic [WIDE_W-1:0] infrared_average
);

  bk_state_t        state;
  bk_state_t        state_next;
  logic             start;
  logic             load_out;
  logic [2:0]       div_busy;
  logic [DIV_W-1:0] uv_quo;
  logic [DIV_W-1:0] vis_quo;
  logic [DIV_W-1:0] ir_quo;

  tcba_div #(.DIVISOR_W(NW)) u_div_uv (
    .clk(clk), .rst(rst), .start(start),
    .dividend(DIV_W'(q_sums.uv_sum)), .divisor(q_size),
    .busy(div_busy[0]), .quotient(uv_quo)
  );

  tcba_div #(.DIVISOR_W(NW)) u_div_vis (
    .clk(clk), .rst(rst), .start(start),
    .dividend(DIV_W'(q_sums.visible_sum)), .divisor(q_size),
    .busy(div_busy[1]), .quotient(vis_quo)
  );

  tcba_div #(.DIVISOR_W(NW)) u_div_ir (
    .clk(clk), .rst(rst), .start(start),
    .dividend(DIV_W'(q_sums.infrared_sum)), .divisor(q_size),
    .busy(div_busy[2]), .quotient(ir_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_RUN;
      BK_RUN:  if (load_out) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    start    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      BK_IDLE: start    = !q_empty;
      BK_RUN:  load_out = (div_busy == '0) && (!m_tvalid || m_tready);
      default: ;
    endcase
  end

  assign q_pop = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      uv_average       <= uv_quo[UV_W-1:0];
      visible_average  <= vis_quo[WIDE_W-1:0];
      infrared_average <= ir_quo[WIDE_W-1:0];
    end
  end

endmodule
